FILE: hw/rtl/kps_pkg.sv
package kps_pkg;

    localparam int CordicSteps = 30;
    localparam logic signed [33:0] CordicInvGain = 34'sh026DD3B6A;

    localparam logic [2:0] REG_SIZE_X  = 3'd0;
    localparam logic [2:0] REG_SIZE_Y  = 3'd1;
    localparam logic [2:0] REG_SIZE_Z  = 3'd2;
    localparam logic [2:0] REG_STEP_X  = 3'd3;
    localparam logic [2:0] REG_STEP_Y  = 3'd4;
    localparam logic [2:0] REG_STEP_Z  = 3'd5;

    localparam logic [12:0] MaxSize = 13'd4096;

    // x, y carry Q1.30 values with growth headroom; z is the signed residue angle
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cordic_beat_t;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        begin
            case (i)
                0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
                2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
                4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
                6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
                8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
                10: t = 32'h000A2F98;  11: t = 32'h000517CC;
                12: t = 32'h00028BE6;  13: t = 32'h000145F3;
                14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
                16: t = 32'h000028BE;  17: t = 32'h0000145F;
                18: t = 32'h00000A30;  19: t = 32'h00000518;
                20: t = 32'h0000028C;  21: t = 32'h00000146;
                22: t = 32'h000000A3;  23: t = 32'h00000051;
                24: t = 32'h00000029;  25: t = 32'h00000014;
                26: t = 32'h0000000A;  27: t = 32'h00000005;
                28: t = 32'h00000003;  29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction

endpackage

FILE: hw/rtl/kspace_phase_ramp_shift.sv
// The data path runs through 3 phase, 30 CORDIC and 4 rotate stages, then the
// output FIFO write and the output register.
// Throughput: one beat per cycle; the pipeline never stalls, and s_ready drops
// only while the 64-entry output FIFO plus the beats in flight hold 63 or more.
// Synchronous active-low reset clears all valid bits, empties the FIFO and
// loads sizes to 1 and phase steps to 0.
module kspace_phase_ramp_shift import kps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_index_x,
    input  logic [11:0]        s_index_y,
    input  logic [11:0]        s_index_z,
    input  logic signed [31:0] s_in_real,
    input  logic signed [31:0] s_in_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_real,
    output logic signed [31:0] m_out_imag
);

    logic [12:0] size_reg [3];
    logic [31:0] step_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '{13'd1, 13'd1, 13'd1};
            step_reg <= '{32'd0, 32'd0, 32'd0};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIZE_X: size_reg[0] <= cfg_data[12:0];
                REG_SIZE_Y: size_reg[1] <= cfg_data[12:0];
                REG_SIZE_Z: size_reg[2] <= cfg_data[12:0];
                REG_STEP_X: step_reg[0] <= cfg_data;
                REG_STEP_Y: step_reg[1] <= cfg_data;
                REG_STEP_Z: step_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output FIFO of depth Depth; the pipe always advances, and input is accepted
    // only while the FIFO can absorb everything in flight, so no beat is lost when m_ready drops.
    localparam int Depth = 64;

    logic adv;
    logic p_valid;
    logic [2:0] ph_valid;
    cordic_beat_t ph_beat, cd_beat;
    logic cd_valid;
    logic signed [31:0] p_re, p_im;

    logic [63:0] fifo_mem [Depth];
    logic [5:0]  wr_ptr_reg, rd_ptr_reg;
    logic [6:0]  count_reg;
    logic [5:0]  inflight_reg;
    logic [63:0] rd_data_reg;
    logic        out_valid_reg;

    logic pop, push, load_out, take;
    assign take     = s_valid && s_ready;
    assign adv      = 1'b1;
    assign push     = p_valid;
    assign load_out = (count_reg != '0) && (!out_valid_reg || m_ready);
    assign pop      = load_out;

    // accept only while the FIFO has room for all beats still in the pipe
    assign s_ready = (7'(count_reg) + 7'(inflight_reg)) < 7'(Depth - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= 6'(inflight_reg + 6'(take) - 6'(push));
        end
    end

    kps_phase u_phase (
        .aclk, .aresetn, .adv,
        .in_valid(take),
        .index_x(s_index_x), .index_y(s_index_y), .index_z(s_index_z),
        .in_re(s_in_real), .in_im(s_in_imag),
        .size_x(size_reg[0]), .size_y(size_reg[1]), .size_z(size_reg[2]),
        .step_x(step_reg[0]), .step_y(step_reg[1]), .step_z(step_reg[2]),
        .valid_o(ph_valid), .beat_o(ph_beat)
    );

    kps_cordic u_cordic (
        .aclk, .aresetn, .adv,
        .in_valid(ph_valid[2]), .beat_i(ph_beat),
        .out_valid(cd_valid), .beat_o(cd_beat)
    );

    kps_rotate u_rotate (
        .aclk, .aresetn, .adv,
        .in_valid(cd_valid), .beat_i(cd_beat),
        .out_valid(p_valid), .out_re(p_re), .out_im(p_im)
    );

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {p_re, p_im};
        end
        if (pop) begin
            rd_data_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 6'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 6'd1;
            count_reg <= 7'(count_reg + 7'(push) - 7'(pop));
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_real = rd_data_reg[63:32];
    assign m_out_imag = rd_data_reg[31:0];

endmodule

FILE: hw/rtl/kps_phase.sv
// Signed frequency index, phase products, and the phase sum: three stages.
module kps_phase import kps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [11:0]        index_x,
    input  logic [11:0]        index_y,
    input  logic [11:0]        index_z,
    input  logic signed [31:0] in_re,
    input  logic signed [31:0] in_im,
    input  logic [12:0]        size_x,
    input  logic [12:0]        size_y,
    input  logic [12:0]        size_z,
    input  logic [31:0]        step_x,
    input  logic [31:0]        step_y,
    input  logic [31:0]        step_z,
    output logic [2:0]         valid_o,
    output cordic_beat_t       beat_o
);

    function automatic logic signed [13:0] sidx(input logic [11:0] idx,
                                                input logic [12:0] size);
        logic [12:0] sz;
        begin
            sz = (size > MaxSize) ? MaxSize : size;
            if ({1'b0, idx} <= (sz >> 1))
                return $signed({2'b00, idx});
            return $signed({2'b00, idx}) - $signed({1'b0, sz});
        end
    endfunction

    logic [2:0]         vld_reg;
    logic signed [13:0] k_reg [3];
    logic [31:0]        p_reg [3];
    logic [31:0]        a_reg;
    logic signed [31:0] re_reg [3];
    logic signed [31:0] im_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k_reg[0]  <= sidx(index_x, size_x);
            k_reg[1]  <= sidx(index_y, size_y);
            k_reg[2]  <= sidx(index_z, size_z);
            re_reg[0] <= in_re;
            im_reg[0] <= in_im;
            // low 32 bits of a two's complement product are sign agnostic
            p_reg[0]  <= 32'({{18{k_reg[0][13]}}, k_reg[0]} * step_x);
            p_reg[1]  <= 32'({{18{k_reg[1][13]}}, k_reg[1]} * step_y);
            p_reg[2]  <= 32'({{18{k_reg[2][13]}}, k_reg[2]} * step_z);
            re_reg[1] <= re_reg[0];
            im_reg[1] <= im_reg[0];
            a_reg     <= 32'd0 - (p_reg[0] + p_reg[1] + p_reg[2]);
            re_reg[2] <= re_reg[1];
            im_reg[2] <= im_reg[1];
        end
    end

    logic [1:0]  q;
    logic [31:0] ru;
    assign q  = 2'((a_reg + 32'h20000000) >> 30);
    assign ru = a_reg - {q, 30'd0};

    assign valid_o     = vld_reg;
    assign beat_o.x    = CordicInvGain;
    assign beat_o.y    = '0;
    assign beat_o.z    = $signed({ru[31], ru});
    assign beat_o.quad = q;
    assign beat_o.re   = re_reg[2];
    assign beat_o.im   = im_reg[2];

endmodule

FILE: hw/rtl/kps_cordic.sv
// One CORDIC iteration per stage.
module kps_cordic import kps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  cordic_beat_t beat_i,
    output logic         out_valid,
    output cordic_beat_t beat_o
);

    cordic_beat_t st_reg [CordicSteps+1];
    logic [CordicSteps:0] vld_reg;

    always_comb begin
        st_reg[0] = beat_i;
    end
    assign vld_reg[0] = in_valid;

    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
        cordic_beat_t nx;
        cordic_beat_t r;
        logic rv;
        always_comb begin
            nx = st_reg[i];
            if (!st_reg[i].z[32]) begin
                nx.x = st_reg[i].x - (st_reg[i].y >>> i);
                nx.y = st_reg[i].y + (st_reg[i].x >>> i);
                nx.z = st_reg[i].z - $signed({1'b0, atan_turns(i)});
            end else begin
                nx.x = st_reg[i].x + (st_reg[i].y >>> i);
                nx.y = st_reg[i].y - (st_reg[i].x >>> i);
                nx.z = st_reg[i].z + $signed({1'b0, atan_turns(i)});
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv <= 1'b0;
            end else if (adv) begin
                rv <= vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                r <= nx;
            end
        end
        always_comb begin
            st_reg[i+1] = r;
        end
        assign vld_reg[i+1] = rv;
    end

    assign out_valid = vld_reg[CordicSteps];
    assign beat_o    = st_reg[CordicSteps];

endmodule

FILE: hw/rtl/kps_rotate.sv
// Quadrant map, complex multiply split into an 8-bit high and a 24-bit low part, round and saturate.
module kps_rotate import kps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  cordic_beat_t       beat_i,
    output logic               out_valid,
    output logic signed [31:0] out_re,
    output logic signed [31:0] out_im
);

    logic [3:0] vld_reg;

    logic signed [33:0] c_reg, s_reg;
    logic signed [31:0] re_reg, im_reg;

    logic signed [67:0] rh_c_reg, ih_s_reg, rh_s_reg, ih_c_reg;
    logic signed [67:0] rl_c_reg, il_s_reg, rl_s_reg, il_c_reg;
    logic signed [67:0] hi_r_reg, hi_i_reg, lo_r_reg, lo_i_reg;
    logic signed [31:0] or_reg, oi_reg;

    logic signed [33:0] cq, sq;
    always_comb begin
        case (beat_i.quad)
            2'd0: begin cq = beat_i.x;  sq = beat_i.y;  end
            2'd1: begin cq = -beat_i.y; sq = beat_i.x;  end
            2'd2: begin cq = -beat_i.x; sq = -beat_i.y; end
            default: begin cq = beat_i.y; sq = -beat_i.x; end
        endcase
    end

    logic signed [7:0]  rh, ih;
    logic signed [24:0] rl, il;
    assign rh = 8'(re_reg >>> 24);
    assign ih = 8'(im_reg >>> 24);
    assign rl = $signed({1'b0, re_reg[23:0]});
    assign il = $signed({1'b0, im_reg[23:0]});

    function automatic logic signed [31:0] sat(input logic signed [67:0] v);
        if (v > 68'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -68'sh80000000)
            return 32'sh80000000;
        return 32'(v);
    endfunction

    logic signed [67:0] sum_r, sum_i;
    assign sum_r = hi_r_reg + (lo_r_reg >>> 24);
    assign sum_i = hi_i_reg + (lo_i_reg >>> 24);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg    <= cq;
            s_reg    <= sq;
            re_reg   <= beat_i.re;
            im_reg   <= beat_i.im;
            // widen before multiplying so the full product is kept
            rh_c_reg <= 68'(42'(rh) * 42'(c_reg));
            ih_s_reg <= 68'(42'(ih) * 42'(s_reg));
            rh_s_reg <= 68'(42'(rh) * 42'(s_reg));
            ih_c_reg <= 68'(42'(ih) * 42'(c_reg));
            rl_c_reg <= 68'(59'(rl) * 59'(c_reg));
            il_s_reg <= 68'(59'(il) * 59'(s_reg));
            rl_s_reg <= 68'(59'(rl) * 59'(s_reg));
            il_c_reg <= 68'(59'(il) * 59'(c_reg));
            hi_r_reg <= rh_c_reg - ih_s_reg;
            hi_i_reg <= rh_s_reg + ih_c_reg;
            lo_r_reg <= rl_c_reg - il_s_reg + 68'sd536870912;
            lo_i_reg <= rl_s_reg + il_c_reg + 68'sd536870912;
            or_reg   <= sat(sum_r >>> 6);
            oi_reg   <= sat(sum_i >>> 6);
        end
    end

    assign out_valid = vld_reg[3];
    assign out_re    = or_reg;
    assign out_im    = oi_reg;

endmodule
